>>> rtl/core/segment_lcd_char_writer_top_defines.svh
// Assertion macros for the segment LCD character writer.
// Used by the port checker; no other dependencies.
`ifndef SEGMENT_LCD_CHAR_WRITER_TOP_DEFINES_SVH
`define SEGMENT_LCD_CHAR_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SLCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slcd check failed");

// Next-cycle implication, disabled while in reset.
`define SLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slcd check failed");

`endif

>>> rtl/core/slcd_pkg.sv
// Shared types, constants and character tables for the segment LCD writer.
// No dependencies.
package slcd_pkg;

    localparam int FRAME_WORDS  = 16;
    localparam int IDX_W        = $clog2(FRAME_WORDS);
    localparam int RAM_INDEX_W  = 4;
    localparam int WORD_W       = 32;
    localparam int SHAPE_W      = 16;
    localparam int CONTRAST_W   = 3;
    localparam int NUM_DIGITS   = 6;
    localparam int BIT_NUM_W    = 5;

    localparam logic [CONTRAST_W-1:0] CONTRAST_RESET = 3'd2;
    localparam logic [CONTRAST_W-1:0] CONTRAST_MAX   = 3'd7;
    localparam logic [CONTRAST_W-1:0] CONTRAST_MIN   = 3'd0;

    localparam logic [SHAPE_W-1:0] POINT_SEG = 16'h0002;
    localparam logic [SHAPE_W-1:0] COLON_SEG = 16'h0020;

    localparam logic [RAM_INDEX_W-1:0] BAR_WORD_ODD  = 4'd4;
    localparam logic [RAM_INDEX_W-1:0] BAR_WORD_EVEN = 4'd6;
    localparam logic [BIT_NUM_W-1:0]   BAR_BIT_LOW   = 5'd8;
    localparam logic [BIT_NUM_W-1:0]   BAR_BIT_HIGH  = 5'd25;

    localparam logic [RAM_INDEX_W-1:0] CHAR_LAST_ONE = 4'd6;
    localparam logic [RAM_INDEX_W-1:0] CHAR_LAST_TWO = 4'd7;
    localparam logic [RAM_INDEX_W-1:0] CLEAR_LAST    = RAM_INDEX_W'(FRAME_WORDS - 1);

    typedef enum logic [2:0] {
        OP_WRITE_CHAR    = 3'd0,
        OP_BAR_ON        = 3'd1,
        OP_BAR_OFF       = 3'd2,
        OP_CLEAR         = 3'd3,
        OP_CONTRAST_UP   = 3'd4,
        OP_CONTRAST_DOWN = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_STEP
    } ctl_state_t;

    typedef struct packed {
        logic                   load;
        logic                   step;
        logic [RAM_INDEX_W-1:0] idx;
    } slcd_cmd_t;

    typedef struct packed {
        logic                   out_free;
        logic                   stride2;
        logic [RAM_INDEX_W-1:0] first_idx;
        logic [RAM_INDEX_W-1:0] final_idx;
    } slcd_status_t;

    localparam logic [SHAPE_W-1:0] NUMERAL_SHAPE [10] = '{
        16'h5F00, 16'h4200, 16'hF500, 16'h6700, 16'hEA00,
        16'hAF00, 16'hBF00, 16'h4600, 16'hFF00, 16'hEF00
    };

    localparam logic [SHAPE_W-1:0] LETTER_SHAPE [26] = '{
        16'hFE00, 16'h6714, 16'h1D00, 16'h4714, 16'h9D00, 16'h9C00, 16'h3F00,
        16'hFA00, 16'h0014, 16'h5300, 16'h9841, 16'h1900, 16'h5A48, 16'h5A09,
        16'h5F00, 16'hFC00, 16'h5F01, 16'hFC01, 16'hAF00, 16'h0414, 16'h5B00,
        16'h18C0, 16'h5A81, 16'h00C9, 16'h0058, 16'h05C0
    };

    localparam logic PLACE_OFF [NUM_DIGITS][4] = '{
        '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b1, 1'b0},
        '{1'b1, 1'b0, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b0, 1'b0}
    };

    localparam logic [BIT_NUM_W-1:0] PLACE_BIT [NUM_DIGITS][4] = '{
        '{5'd4,  5'd23, 5'd22, 5'd3},  '{5'd6,  5'd13, 5'd12, 5'd5},
        '{5'd15, 5'd29, 5'd28, 5'd14}, '{5'd31, 5'd1,  5'd0,  5'd30},
        '{5'd3,  5'd25, 5'd24, 5'd2},  '{5'd17, 5'd8,  5'd9,  5'd26}
    };

    function automatic logic [SHAPE_W-1:0] shape_of(input logic [7:0] c);
        logic [SHAPE_W-1:0] s;
        logic [7:0]         ofs;
        begin
            s   = '0;
            ofs = '0;
            case (c) inside
                8'h20: s = 16'h0000;
                8'h2A: s = 16'hA0DD;
                8'h28: s = 16'h0028;
                8'h29: s = 16'h0011;
                8'h64: s = 16'hF300;
                8'h6D: s = 16'hB210;
                8'h6E: s = 16'h2210;
                8'h2D: s = 16'hA000;
                8'h2B: s = 16'hA014;
                8'h2F: s = 16'h00C0;
                8'h25: s = 16'hB300;
                8'hFF: s = 16'hFFDD;
                [8'h30:8'h39]: s = NUMERAL_SHAPE[c[3:0]];
                [8'h41:8'h5A]:
                begin
                    ofs = c - 8'h41;
                    s   = LETTER_SHAPE[ofs[4:0]];
                end
                [8'h61:8'h7A]:
                begin
                    ofs = c - 8'h61;
                    s   = LETTER_SHAPE[ofs[4:0]];
                end
                default: s = '0;
            endcase
            return s;
        end
    endfunction

endpackage

>>> rtl/core/slcd_datapath.sv
// Datapath: item registers, frame buffer, contrast and the output register.
// Depends on slcd_pkg; driven by slcd_ctrl through slcd_cmd_t.
module slcd_datapath
    import slcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  slcd_cmd_t              cmd,
    output slcd_status_t           status,
    input  logic [2:0]             operation,
    input  logic [7:0]             char_code,
    input  logic                   add_point,
    input  logic                   add_colon,
    input  logic [2:0]             digit_position,
    input  logic [1:0]             bar_index,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   word_valid,
    output logic [RAM_INDEX_W-1:0] ram_index,
    output logic [WORD_W-1:0]      ram_word,
    output logic [CONTRAST_W-1:0]  contrast_level,
    output logic                   last
);

    logic [2:0]             op_reg;
    logic [7:0]             char_reg;
    logic                   point_reg;
    logic                   colon_reg;
    logic [2:0]             pos_reg;
    logic [1:0]             bar_reg;

    logic [WORD_W-1:0]      frame_reg [FRAME_WORDS];
    logic [CONTRAST_W-1:0]  contrast_reg;
    logic [CONTRAST_W-1:0]  contrast_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   word_valid_reg;
    logic                   word_valid_next;
    logic [RAM_INDEX_W-1:0] ram_index_reg;
    logic [RAM_INDEX_W-1:0] ram_index_next;
    logic [WORD_W-1:0]      ram_word_reg;
    logic [WORD_W-1:0]      ram_word_next;
    logic [CONTRAST_W-1:0]  contrast_out_reg;
    logic                   last_reg;
    logic                   last_next;

    logic                   is_char;
    logic                   is_two;
    logic                   is_bar;
    logic                   is_clear;
    logic                   writes;
    logic [2:0]             pos_sel;
    logic [SHAPE_W-1:0]     code;
    logic [3:0]             nib;
    logic [WORD_W-1:0]      char_mask;
    logic [WORD_W-1:0]      char_bits;
    logic [RAM_INDEX_W-1:0] bar_word;
    logic [WORD_W-1:0]      bar_mask;
    logic [IDX_W-1:0]       addr;
    logic [WORD_W-1:0]      old_word;
    logic [WORD_W-1:0]      new_word;

    assign is_char  = (op_reg == OP_WRITE_CHAR) && (pos_reg < 3'(NUM_DIGITS));
    assign is_two   = (pos_reg == 3'd3) || (pos_reg == 3'd4);
    assign is_bar   = (op_reg == OP_BAR_ON) || (op_reg == OP_BAR_OFF);
    assign is_clear = (op_reg == OP_CLEAR);
    assign writes   = is_char || is_bar || is_clear;
    assign pos_sel  = is_char ? pos_reg : 3'd0;

    assign code = shape_of(char_reg) | (point_reg ? POINT_SEG : '0)
                | (colon_reg ? COLON_SEG : '0);
    assign nib  = 4'(code >> {~cmd.idx[2:1], 2'b00});

    assign bar_word = bar_reg[0] ? BAR_WORD_ODD : BAR_WORD_EVEN;
    assign bar_mask = WORD_W'(1) << (bar_reg[1] ? BAR_BIT_HIGH : BAR_BIT_LOW);

    assign addr     = cmd.idx[IDX_W-1:0];
    assign old_word = frame_reg[addr];

    always_comb
    begin
        char_mask = '0;
        char_bits = '0;
        for (int j = 0; j < 4; j++)
        begin
            if (PLACE_OFF[pos_sel][j] == cmd.idx[0])
            begin
                char_mask[PLACE_BIT[pos_sel][j]] = 1'b1;
                char_bits[PLACE_BIT[pos_sel][j]] = nib[j];
            end
        end
    end

    always_comb
    begin
        if (is_char)
        begin
            new_word = (old_word & ~char_mask) | char_bits;
        end
        else if (is_bar)
        begin
            new_word = (op_reg == OP_BAR_ON) ? (old_word | bar_mask)
                                             : (old_word & ~bar_mask);
        end
        else
        begin
            new_word = '0;
        end
    end

    always_comb
    begin
        contrast_next = contrast_reg;
        if ((op_reg == OP_CONTRAST_UP) && (contrast_reg != CONTRAST_MAX))
        begin
            contrast_next = contrast_reg + 3'd1;
        end
        else if ((op_reg == OP_CONTRAST_DOWN) && (contrast_reg != CONTRAST_MIN))
        begin
            contrast_next = contrast_reg - 3'd1;
        end
    end

    always_comb
    begin
        status.out_free  = !out_valid_reg || !out_stall;
        status.stride2   = 1'b0;
        status.first_idx = '0;
        status.final_idx = '0;
        if (is_char)
        begin
            status.stride2   = !is_two;
            status.final_idx = is_two ? CHAR_LAST_TWO : CHAR_LAST_ONE;
        end
        else if (is_bar)
        begin
            status.first_idx = bar_word;
            status.final_idx = bar_word;
        end
        else if (is_clear)
        begin
            status.final_idx = CLEAR_LAST;
        end
    end

    assign out_valid_next  = cmd.step || (out_valid_reg && out_stall);
    assign word_valid_next = writes;
    assign ram_index_next  = writes ? cmd.idx : '0;
    assign ram_word_next   = writes ? new_word : '0;
    assign last_next       = (cmd.idx == status.final_idx);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            char_reg  <= char_code;
            point_reg <= add_point;
            colon_reg <= add_colon;
            pos_reg   <= digit_position;
            bar_reg   <= bar_index;
        end
        if (cmd.step)
        begin
            word_valid_reg   <= word_valid_next;
            ram_index_reg    <= ram_index_next;
            ram_word_reg     <= ram_word_next;
            contrast_out_reg <= contrast_next;
            last_reg         <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_WORDS; i++)
            begin
                frame_reg[i] <= '0;
            end
            contrast_reg  <= CONTRAST_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.step)
            begin
                contrast_reg <= contrast_next;
                if (writes)
                begin
                    frame_reg[addr] <= new_word;
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign word_valid     = word_valid_reg;
    assign ram_index      = ram_index_reg;
    assign ram_word       = ram_word_reg;
    assign contrast_level = contrast_out_reg;
    assign last           = last_reg;

endmodule

>>> rtl/core/slcd_ctrl.sv
// Controller: accepts items and steps the datapath over the frame words.
// Depends on slcd_pkg.
module slcd_ctrl
    import slcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output slcd_cmd_t    cmd,
    input  slcd_status_t status
);

    ctl_state_t             state_reg;
    ctl_state_t             state_next;
    logic [RAM_INDEX_W-1:0] idx_reg;
    logic [RAM_INDEX_W-1:0] idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_STEP;
                idx_next   = status.first_idx;
            end
            ST_STEP:
            begin
                if (status.out_free)
                begin
                    if (idx_reg == status.final_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + (status.stride2 ? 4'd2 : 4'd1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        cmd.idx  = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_PREP:
            begin
                in_stall = 1'b1;
            end
            ST_STEP:
            begin
                cmd.step = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

>>> rtl/core/segment_lcd_char_writer_top.sv
// Top level of the six-digit fourteen-segment LCD character writer.
// Depends on slcd_pkg, slcd_ctrl and slcd_datapath.
//
// Each accepted item is latched, then prepared in the prep state, then
// its frame words are stepped as fast as the output side takes them: a
// character write reports four words (eight for the two middle-right
// digits), a bar write one, clear all sixteen, a contrast step, unused
// code or write past the sixth digit one result with word_valid low.
// The frame buffer is updated one word per cycle, unless the output
// stalls, through a single read-modify-write port. The output register
// lets a new item be taken while the last result still waits.
module segment_lcd_char_writer_top
    import slcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             operation,
    input  logic [7:0]             char_code,
    input  logic                   add_point,
    input  logic                   add_colon,
    input  logic [2:0]             digit_position,
    input  logic [1:0]             bar_index,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   word_valid,
    output logic [RAM_INDEX_W-1:0] ram_index,
    output logic [WORD_W-1:0]      ram_word,
    output logic [CONTRAST_W-1:0]  contrast_level,
    output logic                   last
);

    slcd_cmd_t    cmd;
    slcd_status_t status;

    slcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    slcd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (operation),
        .char_code      (char_code),
        .add_point      (add_point),
        .add_colon      (add_colon),
        .digit_position (digit_position),
        .bar_index      (bar_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .word_valid     (word_valid),
        .ram_index      (ram_index),
        .ram_word       (ram_word),
        .contrast_level (contrast_level),
        .last           (last)
    );

endmodule

>>> rtl/core/slcd_checker.sv
// Port-level checks for the segment LCD character writer, bound to the top.
// Depends on slcd_pkg and segment_lcd_char_writer_top_defines.svh.
`include "segment_lcd_char_writer_top_defines.svh"

module slcd_checker
    import slcd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic [2:0]             operation,
    input logic [7:0]             char_code,
    input logic                   add_point,
    input logic                   add_colon,
    input logic [2:0]             digit_position,
    input logic [1:0]             bar_index,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic                   word_valid,
    input logic [RAM_INDEX_W-1:0] ram_index,
    input logic [WORD_W-1:0]      ram_word,
    input logic [CONTRAST_W-1:0]  contrast_level,
    input logic                   last
);

    `SLCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(ram_word) && $stable(ram_index) && $stable(last))
    `SLCD_ASSERT_NOW(a_no_word_shape, clk, rst_n, out_valid && !word_valid, last && (ram_index == '0) && (ram_word == '0))
    `SLCD_ASSERT_NOW(a_index_range, clk, rst_n, out_valid, int'(ram_index) < FRAME_WORDS)

endmodule

bind segment_lcd_char_writer_top slcd_checker u_slcd_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for segment_lcd_char_writer_top: a directed table, then random items
// with idle gaps and output stalls; checked by a frame buffer predictor or the table row.
// Depends on slcd_pkg and the writer RTL only.
module tb;
    import slcd_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam logic [2:0] SHADE_AT_RESET = 3'd2;
    localparam int LONG_HOLD = 300;
    localparam int RANDOM_ITEMS = 260;

    localparam logic [15:0] DIGIT_GLYPH [10] = '{
        16'h5F00, 16'h4200, 16'hF500, 16'h6700, 16'hEA00,
        16'hAF00, 16'hBF00, 16'h4600, 16'hFF00, 16'hEF00
    };

    localparam logic [15:0] ALPHA_GLYPH [26] = '{
        16'hFE00, 16'h6714, 16'h1D00, 16'h4714, 16'h9D00, 16'h9C00, 16'h3F00,
        16'hFA00, 16'h0014, 16'h5300, 16'h9841, 16'h1900, 16'h5A48, 16'h5A09,
        16'h5F00, 16'hFC00, 16'h5F01, 16'hFC01, 16'hAF00, 16'h0414, 16'h5B00,
        16'h18C0, 16'h5A81, 16'h00C9, 16'h0058, 16'h05C0
    };

    localparam bit LANE_ODD [6][4] = '{
        '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b1, 1'b0},
        '{1'b1, 1'b0, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b0, 1'b0}
    };

    localparam logic [4:0] LANE_BIT [6][4] = '{
        '{5'd4,  5'd23, 5'd22, 5'd3},  '{5'd6,  5'd13, 5'd12, 5'd5},
        '{5'd15, 5'd29, 5'd28, 5'd14}, '{5'd31, 5'd1,  5'd0,  5'd30},
        '{5'd3,  5'd25, 5'd24, 5'd2},  '{5'd17, 5'd8,  5'd9,  5'd26}
    };

    localparam logic [7:0] SYMBOL_CHARS [8] = '{" ", "*", "(", ")", "-", "+", "/", "%"};

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
        logic       pt;
        logic       co;
        logic [2:0] pos;
        logic [1:0] bar;
    } char_item_t;

    typedef struct packed {
        logic                   word_valid;
        logic [RAM_INDEX_W-1:0] ram_index;
        logic [WORD_W-1:0]      ram_word;
        logic [CONTRAST_W-1:0]  contrast_level;
        logic                   last;
    } frame_result_t;

    typedef struct {
        char_item_t    it;
        bit            typed;
        frame_result_t want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid;
    logic                   in_stall;
    logic [2:0]             operation;
    logic [7:0]             char_code;
    logic                   add_point;
    logic                   add_colon;
    logic [2:0]             digit_position;
    logic [1:0]             bar_index;
    logic                   out_valid;
    logic                   out_stall;
    logic                   word_valid;
    logic [RAM_INDEX_W-1:0] ram_index;
    logic [WORD_W-1:0]      ram_word;
    logic [CONTRAST_W-1:0]  contrast_level;
    logic                   last;

    logic [WORD_W-1:0]     frame_mem [FRAME_WORDS];
    logic [CONTRAST_W-1:0] shade;
    frame_result_t         word_expect [$];
    plan_row_t             plan_q [$];
    int                    errors = 0;
    int                    items_sent = 0;
    int                    words_seen = 0;
    int                    clears = 0;
    int                    shade_lo = 7;
    int                    shade_hi = 0;
    bit                    quiet = 1'b0;
    bit                    flood = 1'b0;
    bit                    hold_req = 1'b0;

    segment_lcd_char_writer_top dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [15:0] glyph_for(logic [7:0] c);
        case (c)
            " ":   return 16'h0000;
            "*":   return 16'hA0DD;
            "(":   return 16'h0028;
            ")":   return 16'h0011;
            "d":   return 16'hF300;
            "m":   return 16'hB210;
            "n":   return 16'h2210;
            "-":   return 16'hA000;
            "+":   return 16'hA014;
            "/":   return 16'h00C0;
            "%":   return 16'hB300;
            8'hFF: return 16'hFFDD;
            default: ;
        endcase
        if (c >= "0" && c <= "9")
            return DIGIT_GLYPH[int'(c) - 48];
        if (c >= "A" && c <= "Z")
            return ALPHA_GLYPH[int'(c) - 65];
        if (c >= "a" && c <= "z")
            return ALPHA_GLYPH[int'(c) - 97];
        return 16'h0000;
    endfunction

    function automatic void predict_frame(char_item_t it, bit record);
        frame_result_t batch [FRAME_WORDS];
        int            n;
        int            w;
        int            b;
        logic [15:0]   code;
        n = 0;
        if (it.op == OP_WRITE_CHAR && it.pos < 3'd6)
        begin
            code = glyph_for(it.ch) | (it.pt ? 16'h0002 : 16'h0000)
                 | (it.co ? 16'h0020 : 16'h0000);
            for (int k = 0; k < 4; k++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    w = 2 * k + int'(LANE_ODD[it.pos][j]);
                    frame_mem[w][LANE_BIT[it.pos][j]] = code[12 - 4 * k + j];
                end
            end
            for (int k = 0; k < 8; k++)
            begin
                if (it.pos == 3'd3 || it.pos == 3'd4 || k % 2 == 0)
                begin
                    batch[n] = '{1'b1, RAM_INDEX_W'(k), frame_mem[k], shade, 1'b0};
                    n++;
                end
            end
        end
        else if (it.op == OP_BAR_ON || it.op == OP_BAR_OFF)
        begin
            w = it.bar[0] ? 4 : 6;
            b = it.bar[1] ? 25 : 8;
            frame_mem[w][b] = (it.op == OP_BAR_ON);
            batch[0] = '{1'b1, RAM_INDEX_W'(w), frame_mem[w], shade, 1'b0};
            n = 1;
        end
        else if (it.op == OP_CLEAR)
        begin
            clears++;
            for (int k = 0; k < FRAME_WORDS; k++)
            begin
                frame_mem[k] = '0;
                batch[k] = '{1'b1, RAM_INDEX_W'(k), '0, shade, 1'b0};
            end
            n = FRAME_WORDS;
        end
        else
        begin
            if (it.op == OP_CONTRAST_UP && shade != 3'd7)
                shade = shade + 3'd1;
            else if (it.op == OP_CONTRAST_DOWN && shade != 3'd0)
                shade = shade - 3'd1;
            batch[0] = '{1'b0, '0, '0, shade, 1'b0};
            n = 1;
        end
        if (int'(shade) < shade_lo)
            shade_lo = int'(shade);
        if (int'(shade) > shade_hi)
            shade_hi = int'(shade);
        if (record)
        begin
            for (int i = 0; i < n; i++)
            begin
                batch[i].last = (i == n - 1);
                word_expect.push_back(batch[i]);
            end
        end
    endfunction

    function automatic frame_result_t flat(bit wv, logic [3:0] idx, logic [31:0] word,
                                           logic [2:0] c);
        return '{wv, idx, word, c, 1'b1};
    endfunction

    function automatic void plan(logic [2:0] op, logic [7:0] ch, bit pt, bit co,
                                 logic [2:0] pos, logic [1:0] bar, bit typed = 1'b0,
                                 frame_result_t want = '0);
        plan_row_t r;
        r.it = '{op, ch, pt, co, pos, bar};
        r.typed = typed;
        r.want = want;
        plan_q.push_back(r);
    endfunction

    function automatic char_item_t draw_item();
        char_item_t it;
        int         pick;
        it = '{3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               3'($urandom_range(0, 7)), 2'($urandom_range(0, 3))};
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            it.op = OP_WRITE_CHAR;
            if ($urandom_range(0, 9) != 0)
                it.pos = 3'($urandom_range(0, 5));
            case ($urandom_range(0, 6))
                0: it.ch = 8'h30 + 8'($urandom_range(0, 9));
                1: it.ch = 8'h41 + 8'($urandom_range(0, 25));
                2: it.ch = 8'h61 + 8'($urandom_range(0, 25));
                3: it.ch = SYMBOL_CHARS[$urandom_range(0, 7)];
                4: it.ch = 8'hFF;
                default: ;
            endcase
        end
        else if (pick < 70)
            it.op = ($urandom_range(0, 1) != 0) ? OP_BAR_ON : OP_BAR_OFF;
        else if (pick < 75)
            it.op = OP_CLEAR;
        else if (pick < 90)
            it.op = ($urandom_range(0, 1) != 0) ? OP_CONTRAST_UP : OP_CONTRAST_DOWN;
        else if (pick < 95)
            it.op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
        return it;
    endfunction

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || flood || pick < 60)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(char_item_t it, bit typed = 1'b0, frame_result_t want = '0);
        int gap;
        operation      <= it.op;
        char_code      <= it.ch;
        add_point      <= it.pt;
        add_colon      <= it.co;
        digit_position <= it.pos;
        bar_index      <= it.bar;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_frame(it, !typed);
        if (typed)
            word_expect.push_back(want);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_run(int count);
        char_item_t it;
        int         sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                it = draw_item();
                it.op = ($urandom_range(0, 1) != 0) ? OP_CONTRAST_UP : OP_CONTRAST_DOWN;
                repeat (9) send_item(it);
                sent += 9;
            end
            else
            begin
                send_item(draw_item());
                sent++;
            end
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endfunction

    task automatic take_word();
        frame_result_t got;
        frame_result_t want;
        got = '{word_valid, ram_index, ram_word, contrast_level, last};
        words_seen++;
        if (word_expect.size() == 0)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t: expected no result, got index %0d word %h", $time,
                         got.ram_index, got.ram_word);
        end
        else
        begin
            want = word_expect.pop_front();
            check_field("word_valid", 32'(want.word_valid), 32'(got.word_valid));
            check_field("ram_index", 32'(want.ram_index), 32'(got.ram_index));
            check_field("ram_word", want.ram_word, got.ram_word);
            check_field("contrast_level", 32'(want.contrast_level), 32'(got.contrast_level));
            check_field("last", 32'(want.last), 32'(got.last));
        end
    endtask

    initial
    begin : sink
        int stall_left;
        int pick;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                take_word();
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                stall_left = 0;
            end
            if (stall_left == 0 && !quiet)
            begin
                pick = $urandom_range(0, 99);
                if (pick >= 95)
                    stall_left = $urandom_range(15, 50);
                else if (pick >= 70)
                    stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        in_valid       <= 1'b0;
        operation      <= '0;
        char_code      <= '0;
        add_point      <= 1'b0;
        add_colon      <= 1'b0;
        digit_position <= '0;
        bar_index      <= '0;
        foreach (frame_mem[i])
            frame_mem[i] = '0;
        shade = SHADE_AT_RESET;

        plan(OP_CONTRAST_DOWN, 8'h00, 0, 0, 3'd0, 2'd0, 1, flat(0, 0, 0, 3'd1));
        plan(OP_CONTRAST_DOWN, 8'h00, 0, 0, 3'd0, 2'd0, 1, flat(0, 0, 0, 3'd0));
        plan(OP_CONTRAST_DOWN, 8'h00, 0, 0, 3'd0, 2'd0, 1, flat(0, 0, 0, 3'd0));
        plan(OP_CONTRAST_UP,   8'h00, 0, 0, 3'd0, 2'd0, 1, flat(0, 0, 0, 3'd1));
        plan(OP_UNUSED_LO,     8'hFF, 1, 1, 3'd7, 2'd3, 1, flat(0, 0, 0, 3'd1));
        plan(OP_UNUSED_HI,     8'h00, 0, 0, 3'd0, 2'd0, 1, flat(0, 0, 0, 3'd1));
        plan(OP_BAR_ON,  8'h00, 0, 0, 3'd0, 2'd0, 1, flat(1, 4'd6, 32'h0000_0100, 3'd1));
        plan(OP_BAR_ON,  8'h00, 0, 0, 3'd0, 2'd1, 1, flat(1, 4'd4, 32'h0000_0100, 3'd1));
        plan(OP_BAR_ON,  8'h00, 0, 0, 3'd0, 2'd2, 1, flat(1, 4'd6, 32'h0200_0100, 3'd1));
        plan(OP_BAR_ON,  8'h00, 0, 0, 3'd0, 2'd3, 1, flat(1, 4'd4, 32'h0200_0100, 3'd1));
        plan(OP_BAR_OFF, 8'h00, 0, 0, 3'd0, 2'd2, 1, flat(1, 4'd6, 32'h0000_0100, 3'd1));
        plan(OP_WRITE_CHAR, 8'hFF, 1, 1, 3'd5, 2'd0);
        plan(OP_BAR_OFF,    8'h00, 0, 0, 3'd0, 2'd0);
        plan(OP_WRITE_CHAR, "A", 0, 0, 3'd6, 2'd0, 1, flat(0, 0, 0, 3'd1));
        plan(OP_WRITE_CHAR, "A", 1, 1, 3'd7, 2'd0, 1, flat(0, 0, 0, 3'd1));
        plan(OP_WRITE_CHAR, "d", 1, 0, 3'd3, 2'd0);
        plan(OP_WRITE_CHAR, "m", 0, 1, 3'd4, 2'd0);
        plan(OP_WRITE_CHAR, "n", 0, 0, 3'd0, 2'd0);
        plan(OP_WRITE_CHAR, "*", 0, 0, 3'd1, 2'd0);
        plan(OP_WRITE_CHAR, "%", 1, 0, 3'd2, 2'd0);
        plan(OP_WRITE_CHAR, 8'h00, 0, 1, 3'd5, 2'd0);
        plan(OP_WRITE_CHAR, "Z", 0, 0, 3'd4, 2'd0);
        plan(OP_WRITE_CHAR, "0", 1, 1, 3'd3, 2'd0);
        plan(OP_CLEAR,      8'h00, 0, 0, 3'd0, 2'd0);
        plan(OP_WRITE_CHAR, "a", 1, 1, 3'd0, 2'd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[i])
            send_item(plan_q[i].it, plan_q[i].typed, plan_q[i].want);

        in_valid <= 1'b0;
        while (word_expect.size() != 0)
            @(posedge clk);

        quiet = 1'b1;
        random_run(30);
        quiet = 1'b0;

        hold_req = 1'b1;
        flood = 1'b1;
        random_run(40);
        flood = 1'b0;

        random_run(RANDOM_ITEMS - 70);

        in_valid <= 1'b0;
        while (word_expect.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Summary: %0d items sent, %0d results checked, %0d full clears",
                 items_sent, words_seen, clears);
        $display("Summary: contrast walked %0d..%0d; all op codes, digits and bars driven",
                 shade_lo, shade_hi);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/slcd_pkg.sv
rtl/core/slcd_datapath.sv
rtl/core/slcd_ctrl.sv
rtl/core/segment_lcd_char_writer_top.sv
rtl/core/slcd_checker.sv
tb/tb.sv
